FILE: rtl/itc_pkg.sv
package itc_pkg;

    localparam int MAX_CHANNELS     = 3;
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int COUNT_W          = 16;
    localparam int PORT_W           = 2;
    localparam int MASK_W           = 3;

    localparam logic [PORT_W-1:0] CTRL_PORT      = 2'd3;
    localparam logic [1:0]        RATE_GEN_MODE  = 2'd2;
    localparam logic [COUNT_W:0]  FULL_PERIOD    = 17'h10000;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // read/load access mode from the control word
    typedef enum logic [1:0] {
        AM_LATCH = 2'd0,
        AM_LOW   = 2'd1,
        AM_HIGH  = 2'd2,
        AM_PAIR  = 2'd3
    } am_t;

    // how a count port write lands in the 16-bit count
    typedef enum logic [1:0] {
        LANE_NONE      = 2'd0,
        LANE_LOW_KEEP  = 2'd1,
        LANE_HIGH_KEEP = 2'd2,
        LANE_LOW_CLEAR = 2'd3
    } lane_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PORT_W-1:0] port;
        logic [7:0]        write_data;
    } req_word_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [MASK_W-1:0] expired_mask;
    } rsp_word_t;

    typedef struct packed {
        logic       tick;
        logic       ctrl_wr;
        logic [2:0] ctrl_mode;
        logic       ctrl_copy;
        logic       cnt_wr;
        lane_t      lane;
        logic [7:0] data;
    } chan_cmd_t;

endpackage

FILE: rtl/itc_channel.sv
module itc_channel
    import itc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  chan_cmd_t          cmd,
    output logic [COUNT_W-1:0] count,
    output logic               expired
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] reload_reg, reload_next;
    logic [2:0]         mode_reg, mode_next;
    logic               started_reg, started_next;
    logic [COUNT_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [COUNT_W:0]   period_cur;
    logic [COUNT_W:0]   period_dec;
    logic               active;

    assign active = started_reg && (mode_reg[1:0] == RATE_GEN_MODE);

    // zero means load at this tick; a reload of zero is a full 65536 period
    always_comb
    begin
        if (tick_cnt_reg != '0)
            period_cur = {1'b0, tick_cnt_reg};
        else if (reload_reg == '0)
            period_cur = FULL_PERIOD;
        else
            period_cur = {1'b0, reload_reg};
        period_dec = period_cur - 17'd1;
    end

    always_comb
    begin
        count_next    = count_reg;
        reload_next   = reload_reg;
        mode_next     = mode_reg;
        started_next  = started_reg;
        tick_cnt_next = tick_cnt_reg;
        expired       = 1'b0;

        if (cmd.cnt_wr)
        begin
            unique case (cmd.lane)
                LANE_LOW_KEEP:  count_next = {count_reg[15:8], cmd.data};
                LANE_HIGH_KEEP: count_next = {cmd.data, count_reg[7:0]};
                LANE_LOW_CLEAR: count_next = {8'h00, cmd.data};
                LANE_NONE:      count_next = count_reg;
                default:        count_next = count_reg;
            endcase
            reload_next = count_next;
        end

        if (cmd.ctrl_wr)
        begin
            mode_next = cmd.ctrl_mode;
            if (cmd.ctrl_copy)
                reload_next = count_reg;
            if (!started_reg)
            begin
                started_next  = 1'b1;
                tick_cnt_next = '0;
            end
        end

        if (cmd.tick && active)
        begin
            tick_cnt_next = period_dec[COUNT_W-1:0];
            expired       = (period_dec == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 16'hffff;
            reload_reg   <= 16'hffff;
            mode_reg     <= '0;
            started_reg  <= 1'b0;
            tick_cnt_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            reload_reg   <= reload_next;
            mode_reg     <= mode_next;
            started_reg  <= started_next;
            tick_cnt_reg <= tick_cnt_next;
        end
    end

    assign count = count_reg;

endmodule

FILE: rtl/interval_timer_port_access_unit.sv
// Channel  Words         Handshake            Payload
// req      port access   req_valid/req_stall  req (opcode, port, write_data)
// rsp      result        rsp_valid/rsp_stall  rsp (read_data, expired_mask)
//
// One word per cycle sustained while rsp_stall stays low: a request is captured
// in the input register, then its single-pass update writes the timer state
// and the result register together, which raises rsp_valid.
// Reset (rst_n low, asynchronous) sets counts and reloads to 0xffff, stops
// all channels and clears the access mode and byte toggle.
// A stalled rsp holds the result register; the input register then fills and
// req_stall rises only when both stages hold a word.
module interval_timer_port_access_unit
    import itc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam logic [PORT_W-1:0] NUM_PORTS = PORT_W'(NUM_CHANNELS);

    // input stage
    logic      s1_valid_reg, s1_valid_next;
    req_word_t s1_reg, s1_next;

    // result stage
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_word_reg, rsp_word_next;

    // shared access state
    am_t       am_reg, am_next;
    logic      low_byte_next_reg, low_byte_next_next;

    logic               adv;
    logic               is_read, is_write, is_tick, is_ctrl, port_ok;
    logic [1:0]         sel;
    logic               sel_ok;
    logic [COUNT_W-1:0] sel_count;
    lane_t              lane;
    logic [7:0]         rd_byte;

    chan_cmd_t          cmd   [NUM_CHANNELS];
    logic [COUNT_W-1:0] count [NUM_CHANNELS];
    logic               expired [NUM_CHANNELS];
    logic [MASK_W-1:0]  mask;

    // advance the input word when the result register is free or draining
    assign adv       = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !adv;

    assign is_read  = (s1_reg.opcode == OP_READ);
    assign is_write = (s1_reg.opcode == OP_WRITE);
    assign is_tick  = (s1_reg.opcode == OP_TICK);
    assign is_ctrl  = (s1_reg.port == CTRL_PORT);
    assign port_ok  = (s1_reg.port < NUM_PORTS);
    assign sel      = s1_reg.write_data[7:6];
    assign sel_ok   = (sel < NUM_PORTS);

    // pick the addressed channel's count
    always_comb
    begin
        sel_count = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (s1_reg.port == PORT_W'(c))
                sel_count = count[c];
        end
    end

    // byte lane of a read or write, following the shared toggle in pair mode
    always_comb
    begin
        unique case (am_reg)
            AM_LATCH:
            begin
                rd_byte = '0;
                lane    = LANE_NONE;
            end
            AM_LOW:
            begin
                rd_byte = sel_count[7:0];
                lane    = LANE_LOW_KEEP;
            end
            AM_HIGH:
            begin
                rd_byte = sel_count[15:8];
                lane    = LANE_HIGH_KEEP;
            end
            AM_PAIR:
            begin
                rd_byte = low_byte_next_reg ? sel_count[7:0] : sel_count[15:8];
                lane    = low_byte_next_reg ? LANE_LOW_CLEAR : LANE_HIGH_KEEP;
            end
            default:
            begin
                rd_byte = '0;
                lane    = LANE_NONE;
            end
        endcase
    end

    // per-channel commands
    always_comb
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            cmd[c].tick      = adv && is_tick;
            cmd[c].ctrl_wr   = adv && is_write && is_ctrl && sel_ok && (sel == 2'(c));
            cmd[c].ctrl_mode = s1_reg.write_data[3:1];
            cmd[c].ctrl_copy = (am_t'(s1_reg.write_data[5:4]) == AM_LATCH);
            cmd[c].cnt_wr    = adv && is_write && !is_ctrl && (s1_reg.port == PORT_W'(c));
            cmd[c].lane      = lane;
            cmd[c].data      = s1_reg.write_data;
        end
    end

    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_chan
        itc_channel u_chan (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd[g]),
            .count   (count[g]),
            .expired (expired[g])
        );
    end

    always_comb
    begin
        mask = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
            mask[c] = expired[c];
    end

    // access mode and toggle
    always_comb
    begin
        am_next            = am_reg;
        low_byte_next_next = low_byte_next_reg;
        if (adv)
        begin
            if (is_write && is_ctrl)
            begin
                if (sel_ok)
                begin
                    am_next = am_t'(s1_reg.write_data[5:4]);
                    if (am_t'(s1_reg.write_data[5:4]) == AM_PAIR)
                        low_byte_next_next = 1'b1;
                end
            end
            else if ((is_read || is_write) && port_ok && (am_reg == AM_PAIR))
                low_byte_next_next = !low_byte_next_reg;
        end
    end

    // pipeline control: load input when not stalled, result when advancing
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (!req_stall)
        begin
            s1_valid_next = req_valid;
            s1_next       = req;
        end

        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (adv)
        begin
            rsp_valid_next              = 1'b1;
            rsp_word_next.read_data     = (is_read && port_ok) ? rd_byte : 8'h00;
            rsp_word_next.expired_mask  = mask;
        end
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            am_reg            <= AM_LATCH;
            low_byte_next_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            rsp_valid_reg     <= rsp_valid_next;
            am_reg            <= am_next;
            low_byte_next_reg <= low_byte_next_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // only ticks may flag expirations
    a_mask_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !is_tick) |=> (rsp_word_reg.expired_mask == '0))
        else $error("expired mask set on a non-tick word");

    // only reads return data
    a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !is_read) |=> (rsp_word_reg.read_data == 8'h00))
        else $error("read data on a non-read word");

    // a paired access to a valid count port flips the toggle
    a_pair_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (is_read || is_write) && !is_ctrl && port_ok && (am_reg == AM_PAIR))
        |=> (low_byte_next_reg != $past(low_byte_next_reg)))
        else $error("paired access did not flip the byte toggle");

    // a blocked input word holds until the result side frees up
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("input stage lost or changed a blocked word");

endmodule
